>>> rtl/paged_frame_allocator_unit_assert.svh
// Assertion macros shared by the frame allocator RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef PAGED_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGED_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define PFA_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error(msg);

`endif

>>> rtl/pfa_pkg.sv
// Package for the paged frame allocator: sizes, codes and shared structs.
// No dependencies; every other RTL file but the assertion header imports it.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_SIZE = 32;

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int REQ_W   = 16;
  localparam int PAGES_W = $clog2((2 ** REQ_W - 1) / PAGE_SIZE + 2);
  localparam int CMP_W   = (PAGES_W > CNT_W) ? PAGES_W : CNT_W;
  localparam int ID_W    = 8;
  localparam int NEXT_W  = 9;
  localparam int STAT_W  = 2;
  localparam int FIELD_W = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_ID     = 2'd3;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] idx;
    logic [ID_W-1:0]    owner;
  } pfa_wr_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    owner_id;
    logic [FIELD_W-1:0] page_count;
    logic [FIELD_W-1:0] lost_units;
    logic [FIELD_W-1:0] free_frames;
  } pfa_rsp_t;

endpackage

`default_nettype wire

>>> rtl/pfa_req_if.sv
// Request channel of the frame allocator: valid/ready plus the item fields.
// Depends on pfa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfa_req_if import pfa_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [REQ_W-1:0] request_size;
  logic [ID_W-1:0]  process_id;

  modport source (output valid, output opcode, output request_size, output process_id,
                  input ready);
  modport sink (input valid, input opcode, input request_size, input process_id,
                output ready);
endinterface

`default_nettype wire

>>> rtl/pfa_rsp_if.sv
// Response channel of the frame allocator: valid/ready plus the result fields.
// Depends on pfa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfa_rsp_if import pfa_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ID_W-1:0]    owner_id;
  logic [FIELD_W-1:0] page_count;
  logic [FIELD_W-1:0] lost_units;
  logic [FIELD_W-1:0] free_frames;

  modport source (output valid, output status, output owner_id, output page_count,
                  output lost_units, output free_frames, input ready);
  modport sink (input valid, input status, input owner_id, input page_count,
                input lost_units, input free_frames, output ready);
endinterface

`default_nettype wire

>>> rtl/pfa_frame_table.sv
// Frame ownership table: one owner id per frame, zero meaning free.
// Depends on pfa_pkg; one read port at the scan index, one write port.
`timescale 1ns / 1ps
`default_nettype none

module pfa_frame_table import pfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [FRAME_W-1:0] rd_idx,
  output logic [ID_W-1:0]    rd_owner,
  input  pfa_wr_t            wr
);

  logic [ID_W-1:0] owner [FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        owner[i] <= '0;
      end
    end else if (wr.en) begin
      owner[wr.idx] <= wr.owner;
    end
  end

  assign rd_owner = owner[rd_idx];

endmodule

`default_nettype wire

>>> rtl/pfa_seq.sv
// Sequencer and shared scan unit: sizes a request, then walks the frame table
// one frame a cycle. Depends on pfa_pkg, pfa_req_if and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "paged_frame_allocator_unit_assert.svh"

module pfa_seq import pfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pfa_req_if.sink            req,
  output pfa_rsp_t           res,
  output logic               res_valid,
  input  logic               res_take,
  output logic [FRAME_W-1:0] rd_idx,
  input  logic [ID_W-1:0]    rd_owner,
  output pfa_wr_t            wr
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state;
  logic               op;
  logic [REQ_W-1:0]   req_size;
  logic [ID_W-1:0]    pid;
  logic [CMP_W-1:0]   pages;
  logic [FIELD_W-1:0] lost;
  logic [STAT_W-1:0]  status;
  logic [FRAME_W-1:0] idx;
  logic [CNT_W-1:0]   given;
  logic [CNT_W-1:0]   free_count;
  logic [NEXT_W-1:0]  next_owner;

  logic [REQ_W-1:0]   rem;
  logic [CMP_W-1:0]   pages_calc;
  logic [FIELD_W-1:0] lost_calc;
  logic               hit;
  logic               alloc_ok;
  logic               free_ok;
  logic [STAT_W-1:0]  fin_status;
  logic [CNT_W-1:0]   free_after;

  function automatic logic status_setup_err(input logic o, input logic [NEXT_W-1:0] nxt,
                                            input logic [CMP_W-1:0] pg,
                                            input logic [CNT_W-1:0] fc);
    logic err;
    err = (o == OP_ALLOC) && (nxt[NEXT_W-1] || (pg > CMP_W'(fc)));
    return err;
  endfunction

  assign req.ready = (state == S_IDLE);

  // Round the request up to whole pages; the remainder gives the slack.
  assign rem        = REQ_W'(req_size % PAGE_SIZE);
  assign pages_calc = CMP_W'(req_size / PAGE_SIZE) + CMP_W'(rem != '0);
  assign lost_calc  = (rem != '0) ? FIELD_W'(PAGE_SIZE - int'(rem)) : '0;

  // Shared compare: a free frame for an allocation, a matching owner for a release.
  always_comb begin
    if (op == OP_ALLOC) begin
      hit = (rd_owner == '0) && (CMP_W'(given) < pages);
    end else begin
      hit = (pid != '0) && (rd_owner == pid);
    end
  end

  assign rd_idx   = idx;
  assign wr.en    = (state == S_SCAN) && hit;
  assign wr.idx   = idx;
  assign wr.owner = (op == OP_ALLOC) ? next_owner[ID_W-1:0] : '0;

  assign fin_status = (status == ST_OK && op == OP_FREE && given == '0) ? ST_NOT_FOUND
                                                                      : status;
  assign alloc_ok   = (fin_status == ST_OK) && (op == OP_ALLOC);
  assign free_ok    = (fin_status == ST_OK) && (op == OP_FREE);

  always_comb begin
    if (alloc_ok) begin
      free_after = free_count - given;
    end else if (free_ok) begin
      free_after = free_count + given;
    end else begin
      free_after = free_count;
    end
  end

  assign res_valid        = (state == S_DONE);
  assign res.status       = fin_status;
  assign res.owner_id     = alloc_ok ? next_owner[ID_W-1:0] : (free_ok ? pid : '0);
  assign res.page_count   = (fin_status == ST_OK) ? FIELD_W'(given) : '0;
  assign res.lost_units   = alloc_ok ? lost : '0;
  assign res.free_frames  = FIELD_W'(free_after);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= CNT_W'(FRAMES);
      next_owner <= NEXT_W'(1);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= (status_setup_err(op, next_owner, pages_calc, free_count)) ? S_DONE
                                                                              : S_SCAN;
        end
        S_SCAN: begin
          if (idx == FRAME_W'(FRAMES - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state      <= S_IDLE;
            free_count <= free_after;
            if (alloc_ok) begin
              next_owner <= next_owner + NEXT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item and scan datapath; none of it needs a reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op       <= req.opcode;
      req_size <= req.request_size;
      pid      <= req.process_id;
    end
    if (state == S_SETUP) begin
      pages <= pages_calc;
      lost  <= lost_calc;
      idx   <= '0;
      given <= '0;
      if (op == OP_ALLOC && next_owner[NEXT_W-1]) begin
        status <= ST_NO_ID;
      end else if (op == OP_ALLOC && pages_calc > CMP_W'(free_count)) begin
        status <= ST_NO_MEM;
      end else begin
        status <= ST_OK;
      end
    end
    if (state == S_SCAN) begin
      idx   <= idx + FRAME_W'(1);
      given <= given + CNT_W'(hit);
    end
  end

  `PFA_ASSERT(a_free_bound, free_count <= CNT_W'(FRAMES), "free count above frame total")
  `PFA_ASSERT(a_wr_in_scan, wr.en |-> state == S_SCAN, "table write outside the scan")
  `PFA_ASSERT(a_alloc_cap, (state == S_SCAN && op == OP_ALLOC) |-> CMP_W'(given) <= pages,
              "more frames taken than pages requested")
  `PFA_ASSERT_NEXT(a_take_idle, state == S_DONE && res_take, state == S_IDLE,
                   "sequencer did not return to idle after its result")

endmodule

`default_nettype wire

>>> rtl/paged_frame_allocator_unit.sv
// Paged frame allocator, top level. An item passes through set-up and then
// through the shared scan unit, which walks the frame table one frame a cycle;
// a request that fails its id or size check skips the scan. A result is handed
// to the output register from the done state, and a new item is accepted only
// once the last one has handed over its result. Synchronous reset frees every
// frame, sets the free count to the frame total and the next owner id to one.
`timescale 1ns / 1ps
`default_nettype none

module paged_frame_allocator_unit import pfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp
);

  // The sequencer owns the request side: it raises ready only while idle, so
  // one item is in the scan at a time.
  pfa_rsp_t           res;
  logic               res_valid;
  logic               res_take;
  logic [FRAME_W-1:0] rd_idx;
  logic [ID_W-1:0]    rd_owner;
  pfa_wr_t            wr;

  // Output register. The sequencer may start the next item while a finished
  // beat waits here; it only stalls in its done state if this slot is still
  // full when the next result is ready.
  logic     out_valid;
  pfa_rsp_t out_data;
  logic     slot_free;

  pfa_frame_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_owner (rd_owner),
    .wr       (wr)
  );

  pfa_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .rd_idx    (rd_idx),
    .rd_owner  (rd_owner),
    .wr        (wr)
  );

  assign slot_free = !out_valid || rsp.ready;
  assign res_take  = res_valid && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The payload is loaded only when the sequencer hands over a result.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_data.status;
  assign rsp.owner_id    = out_data.owner_id;
  assign rsp.page_count  = out_data.page_count;
  assign rsp.lost_units  = out_data.lost_units;
  assign rsp.free_frames = out_data.free_frames;

endmodule

`default_nettype wire
